// File: design/sha256_pkg.sv
`default_nettype none

package sha256_pkg;

    localparam int WORD_W     = 32;
    localparam int VBYTES_W   = 3;
    localparam int LEN_W      = 64;
    localparam int NUM_CHAIN  = 8;
    localparam int NUM_WIN    = 16;
    localparam int NUM_ROUNDS = 64;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS);
    localparam int WCNT_W     = $clog2(NUM_WIN);
    localparam int IDX_W      = $clog2(NUM_CHAIN);

    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [VBYTES_W-1:0] t_vbytes;
    typedef logic [LEN_W-1:0]    t_len;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam t_vbytes    FULL_BYTES = 3'd4;

    localparam t_word IV_TABLE [NUM_CHAIN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TABLE [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

`default_nettype wire

// File: design/sha256_if.sv
`default_nettype none

interface sha256_in_if;
    logic                     valid;
    logic                     ready;
    sha256_pkg::t_word        message_word;
    sha256_pkg::t_vbytes      valid_bytes;
    logic                     final_word;

    modport source(output valid, output message_word, output valid_bytes,
                   output final_word, input ready);
    modport sink(input valid, input message_word, input valid_bytes,
                 input final_word, output ready);
endinterface

interface sha256_out_if;
    logic                              valid;
    logic                              ready;
    sha256_pkg::t_word                 digest_word;
    logic [sha256_pkg::IDX_W-1:0]      word_index;
    logic                              last_word;

    modport source(output valid, output digest_word, output word_index,
                   output last_word, input ready);
    modport sink(input valid, input digest_word, input word_index,
                 input last_word, output ready);
endinterface

`default_nettype wire

// File: design/sha256_hash_core_top.sv
// Each accepted word fills one slot of a 16-word block; a full block then runs its 64
// rounds and a fold, during which no item is accepted. A final word adds up to two
// padding blocks, then 8 digest items, one per cycle while the receiver is ready.
// Throughput is set by the single shared round unit: one SHA-256 round per cycle.
// Reset (i_rst_n low, synchronous) loads the initial hash, clears the length and
// the word count, and leaves the block ready for a new message.
`default_nettype none

module sha256_hash_core_top (
    input  wire              i_clk,
    input  wire              i_rst_n,
    sha256_in_if.sink        i_in,
    sha256_out_if.source     o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam int NW = sha256_pkg::NUM_WIN;
    localparam int NC = sha256_pkg::NUM_CHAIN;

    logic [2:0]                         r_state, n_state;
    logic [sha256_pkg::WCNT_W-1:0]      r_cnt, n_cnt;
    logic [sha256_pkg::ROUND_W-1:0]     r_rnd, n_rnd;
    logic [sha256_pkg::IDX_W-1:0]       r_idx, n_idx;
    sha256_pkg::t_len                   r_len, n_len;
    logic                               r_final, n_final;
    logic                               r_pad_pend, n_pad_pend;
    logic                               r_len_hi, n_len_hi;
    logic                               r_len_done, n_len_done;
    logic                               w_restart;

    sha256_pkg::t_word  r_win   [NW];
    sha256_pkg::t_word  r_v     [NC];
    sha256_pkg::t_word  r_chain [NC];

    logic                 w_push;
    sha256_pkg::t_word    w_push_word;
    sha256_pkg::t_vbytes  w_vb;
    sha256_pkg::t_word    w_padded;
    sha256_pkg::t_word    w_sched;
    sha256_pkg::t_word    w_wt;
    sha256_pkg::t_word    w_t1;
    sha256_pkg::t_word    w_t2;
    sha256_pkg::t_word    w_ch;
    sha256_pkg::t_word    w_maj;
    logic                 w_in_acc;
    logic                 w_out_acc;

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = (r_state == S_OUT);
    assign o_out.digest_word = r_chain[r_idx];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == sha256_pkg::IDX_W'(NC - 1));

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    // Clamp byte count and place the pad byte after the last message byte
    always_comb begin
        w_vb = (i_in.valid_bytes > sha256_pkg::FULL_BYTES) ? sha256_pkg::FULL_BYTES
                                                           : i_in.valid_bytes;
        case (w_vb)
            3'd0:    w_padded = {sha256_pkg::PAD_BYTE, 24'h0};
            3'd1:    w_padded = {i_in.message_word[31:24], sha256_pkg::PAD_BYTE, 16'h0};
            3'd2:    w_padded = {i_in.message_word[31:16], sha256_pkg::PAD_BYTE, 8'h0};
            3'd3:    w_padded = {i_in.message_word[31:8], sha256_pkg::PAD_BYTE};
            default: w_padded = i_in.message_word;
        endcase
    end

    // Shared round unit: schedule word and one compression round
    always_comb begin
        w_sched = r_win[0] + r_win[9] + sha256_pkg::small_sigma0(r_win[1])
                + sha256_pkg::small_sigma1(r_win[14]);
        w_wt    = (r_rnd[sha256_pkg::ROUND_W-1:4] == '0) ? r_win[0] : w_sched;
        w_ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj   = (r_v[0] & r_v[1]) ^ (r_v[1] & r_v[2]) ^ (r_v[0] & r_v[2]);
        w_t1    = r_v[7] + sha256_pkg::big_sigma1(r_v[4]) + w_ch
                + sha256_pkg::K_TABLE[r_rnd] + w_wt;
        w_t2    = sha256_pkg::big_sigma0(r_v[0]) + w_maj;
    end

    // Sequencer: collect words, pad, run rounds, fold, emit digest
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rnd       = r_rnd;
        n_idx       = r_idx;
        n_len       = r_len;
        n_final     = r_final;
        n_pad_pend  = r_pad_pend;
        n_len_hi    = r_len_hi;
        n_len_done  = r_len_done;
        w_push      = 1'b0;
        w_push_word = '0;
        w_restart   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_push = 1'b1;
                    if (i_in.final_word) begin
                        w_push_word = w_padded;
                        n_len       = r_len + sha256_pkg::LEN_W'({w_vb, 3'b000});
                        n_final     = 1'b1;
                        n_pad_pend  = (w_vb == sha256_pkg::FULL_BYTES);
                        n_state     = S_PAD;
                    end else begin
                        w_push_word = i_in.message_word;
                        n_len       = r_len + sha256_pkg::LEN_W'(32);
                    end
                end
            end
            S_PAD: begin
                w_push = 1'b1;
                if (r_pad_pend) begin
                    w_push_word = {sha256_pkg::PAD_BYTE, 24'h0};
                    n_pad_pend  = 1'b0;
                end else if (r_cnt == sha256_pkg::WCNT_W'(NW - 2)) begin
                    w_push_word = r_len[63:32];
                    n_len_hi    = 1'b1;
                end else if (r_cnt == sha256_pkg::WCNT_W'(NW - 1) && r_len_hi) begin
                    w_push_word = r_len[31:0];
                    n_len_done  = 1'b1;
                end
            end
            S_ROUND: begin
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == sha256_pkg::ROUND_W'(sha256_pkg::NUM_ROUNDS - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (r_len_done) begin
                    n_state = S_OUT;
                    n_idx   = '0;
                end else if (r_final) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == sha256_pkg::IDX_W'(NC - 1)) begin
                        w_restart  = 1'b1;
                        n_state    = S_IDLE;
                        n_len      = '0;
                        n_final    = 1'b0;
                        n_pad_pend = 1'b0;
                        n_len_hi   = 1'b0;
                        n_len_done = 1'b0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a full block starts the rounds
        if (w_push) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == sha256_pkg::WCNT_W'(NW - 1)) begin
                n_state = S_ROUND;
                n_rnd   = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_rnd      <= '0;
            r_idx      <= '0;
            r_len      <= '0;
            r_final    <= 1'b0;
            r_pad_pend <= 1'b0;
            r_len_hi   <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_rnd      <= n_rnd;
            r_idx      <= n_idx;
            r_len      <= n_len;
            r_final    <= n_final;
            r_pad_pend <= n_pad_pend;
            r_len_hi   <= n_len_hi;
            r_len_done <= n_len_done;
        end
    end

    // Chaining value: load initial hash, fold working variables after a block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_restart) begin
            for (int j = 0; j < NC; j++) begin
                r_chain[j] <= sha256_pkg::IV_TABLE[j];
            end
        end else if (r_state == S_FOLD) begin
            for (int j = 0; j < NC; j++) begin
                r_chain[j] <= r_chain[j] + r_v[j];
            end
        end
    end

    // Schedule window: shift in pushed words, rotate through it during rounds
    always_ff @(posedge i_clk) begin
        if (w_push || r_state == S_ROUND) begin
            for (int p = 0; p < NW - 1; p++) begin
                r_win[p] <= r_win[p+1];
            end
            r_win[NW-1] <= w_push ? w_push_word : w_wt;
        end
    end

    // Working variables: load from the chain at block start, advance per round
    always_ff @(posedge i_clk) begin
        if (w_push && r_cnt == sha256_pkg::WCNT_W'(NW - 1)) begin
            for (int j = 0; j < NC; j++) begin
                r_v[j] <= r_chain[j];
            end
        end else if (r_state == S_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

endmodule

`default_nettype wire

// File: design/sha256_checker.sv
`default_nettype none

module sha256_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [sha256_pkg::WORD_W-1:0] i_digest_word,
    input wire [sha256_pkg::IDX_W-1:0]  i_word_index,
    input wire                           i_last_word
);

    // A stalled digest item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_digest_word)
            && $stable(i_word_index))
        else $error("stalled digest item changed");

    // No input is taken while a digest is being emitted
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input ready during digest output");

    // Digest items follow one another in index order
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last_word |=>
            i_out_valid && i_word_index == $past(i_word_index) + 1'b1)
        else $error("digest index did not advance");

    // The last digest item returns the block to ready
    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last_word |=> i_in_ready && !i_out_valid)
        else $error("block not ready after digest");

    // Reset leaves the block ready and silent
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready && !i_out_valid)
        else $error("bad state after reset");

endmodule

bind sha256_hash_core_top sha256_checker u_sha256_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_digest_word(o_out.digest_word),
    .i_word_index (o_out.word_index),
    .i_last_word  (o_out.last_word)
);

`default_nettype wire

// File: test/tb.sv
module tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTS = 25;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam sha256_pkg::t_word INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam sha256_pkg::t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        sha256_pkg::t_word            digest;
        logic [sha256_pkg::IDX_W-1:0] index;
        logic                         last;
    } t_digest_rec;

    logic i_clk;
    logic i_rst_n;

    sha256_in_if  in_if();
    sha256_out_if out_if();

    sha256_hash_core_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Predicted hash state
    sha256_pkg::t_word hash_state [8];
    sha256_pkg::t_word block_words [16];
    sha256_pkg::t_len  msg_bits;
    logic [3:0]        fill_count;
    t_digest_rec       pending_digest [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int words_sent;
    int messages_sent;
    int digests_checked;
    int quiet_cycles;

    always #4 i_clk = ~i_clk;

    function automatic sha256_pkg::t_word rotr(input sha256_pkg::t_word x,
                                               input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void clear_hash_state();
        hash_state = INIT_HASH;
        msg_bits   = '0;
        fill_count = '0;
    endfunction

    // Run the 64 rounds on the collected block and fold into the chaining value
    function automatic void compress_block();
        sha256_pkg::t_word v [8];
        sha256_pkg::t_word w15, w2, w7, t1, t2;
        int    slot;
        v = hash_state;
        for (int r = 0; r < 64; r++) begin
            slot = r % 16;
            if (r >= 16) begin
                w15 = block_words[(r - 15) % 16];
                w2  = block_words[(r - 2) % 16];
                w7  = block_words[(r - 7) % 16];
                block_words[slot] = block_words[slot] + w7
                    + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                    + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + block_words[slot];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[1] & v[2]) ^ (v[0] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
            hash_state[j] = hash_state[j] + v[j];
    endfunction

    function automatic void push_block_word(input sha256_pkg::t_word w);
        block_words[fill_count] = w;
        fill_count = fill_count + 1'b1;
        if (fill_count == 0)
            compress_block();
    endfunction

    // Fold one accepted item into the predicted state; on the final word pad and emit
    function automatic void absorb_word(input sha256_pkg::t_word data,
                                        input sha256_pkg::t_vbytes nbytes,
                                        input logic last);
        int    used;
        sha256_pkg::t_word keep;
        if (!last) begin
            push_block_word(data);
            msg_bits = msg_bits + 64'd32;
            return;
        end
        used = (nbytes > sha256_pkg::FULL_BYTES) ? 4 : int'(nbytes);
        msg_bits = msg_bits + sha256_pkg::t_len'(used * 8);
        if (used == 4) begin
            push_block_word(data);
            push_block_word({PAD_MARK, 24'h0});
        end else begin
            keep = (used == 0) ? '0 : ('1 << (32 - 8 * used));
            push_block_word((data & keep)
                | (sha256_pkg::t_word'(PAD_MARK) << (24 - 8 * used)));
        end
        while (fill_count != 4'd14)
            push_block_word('0);
        push_block_word(msg_bits[63:32]);
        push_block_word(msg_bits[31:0]);
        for (int j = 0; j < 8; j++)
            pending_digest.push_back(t_digest_rec'{hash_state[j],
                                     sha256_pkg::IDX_W'(j), j == 7});
        clear_hash_state();
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Drive one item and hold it until the block takes it
    task automatic send_word(input sha256_pkg::t_word data,
                             input sha256_pkg::t_vbytes nbytes, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.message_word <= data;
        in_if.valid_bytes  <= nbytes;
        in_if.final_word   <= last;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        absorb_word(data, nbytes, last);
        words_sent++;
        if (last)
            messages_sent++;
    endtask

    // Drop valid and hold off until every predicted digest word has come back
    task automatic wait_for_digests();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic sha256_pkg::t_word pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_message(input int body_words, input sha256_pkg::t_vbytes tail_bytes);
        for (int k = 0; k < body_words; k++)
            send_word(pick_word(), sha256_pkg::t_vbytes'($urandom_range(7)), 1'b0);
        send_word(pick_word(), tail_bytes, 1'b1);
    endtask

    task automatic set_pacing(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic test_empty_message();
        // message word is ignored when no byte is used
        send_word('1, 3'd0, 1'b1);
    endtask

    task automatic test_partial_final_words();
        for (int b = 1; b < 4; b++)
            send_word('1, sha256_pkg::t_vbytes'(b), 1'b1);
    endtask

    task automatic test_full_final_word();
        send_word('1, sha256_pkg::FULL_BYTES, 1'b1);
    endtask

    task automatic test_oversized_byte_count();
        for (int b = 5; b < 8; b++)
            send_word(32'hA5C3_0F96, sha256_pkg::t_vbytes'(b), 1'b1);
    endtask

    task automatic test_extra_padding_block();
        // pad lands in the first length slot, so a second padding block follows
        for (int k = 0; k < 13; k++)
            send_word((k % 2) ? '1 : '0, sha256_pkg::t_vbytes'(k % 8), 1'b0);
        send_word(32'hFFFF_FFFF, sha256_pkg::FULL_BYTES, 1'b1);
    endtask

    task automatic test_idle_gap_between_messages();
        send_word(32'h6162_6300, 3'd3, 1'b1);
        wait_for_digests();
        send_word(32'h1234_5678, 3'd2, 1'b1);
    endtask

    task automatic test_random_messages(input int target_items);
        int start;
        int body;
        start = words_sent;
        while (words_sent - start < target_items) begin
            body = ($urandom_range(5) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
            send_message(body, sha256_pkg::t_vbytes'($urandom_range(7)));
            if ($urandom_range(7) == 0)
                wait_for_digests();
        end
    endtask

    // Receiver stalls at random, driven on the falling edge
    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each digest item with the oldest prediction
    always @(posedge i_clk) begin : check_digest
        t_digest_rec want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            digests_checked++;
            if (pending_digest.size() == 0) begin
                report_mismatch($sformatf("unexpected digest word %08h index %0d",
                                          out_if.digest_word, out_if.word_index));
            end else begin
                want = pending_digest.pop_front();
                if (out_if.digest_word !== want.digest)
                    report_mismatch($sformatf("digest_word %08h, want %08h (index %0d)",
                                              out_if.digest_word, want.digest, want.index));
                if (out_if.word_index !== want.index)
                    report_mismatch($sformatf("word_index %0d, want %0d",
                                              out_if.word_index, want.index));
                if (out_if.last_word !== want.last)
                    report_mismatch($sformatf("last_word %0b, want %0b (index %0d)",
                                              out_if.last_word, want.last, want.index));
            end
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.message_word = '0;
        in_if.valid_bytes  = '0;
        in_if.final_word   = 1'b0;
        out_if.ready       = 1'b0;
        quiet_cycles       = 0;
        error_count        = 0;
        words_sent         = 0;
        messages_sent      = 0;
        digests_checked    = 0;
        clear_hash_state();
        set_pacing(17, 77);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_partial_final_words();
        test_full_final_word();
        test_oversized_byte_count();
        test_extra_padding_block();
        test_idle_gap_between_messages();
        test_random_messages(60);

        set_pacing(77, 17);
        test_random_messages(60);

        set_pacing(0, 0);
        test_random_messages(60);

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (pending_digest.size() != 0)
            report_mismatch($sformatf("%0d digest words never arrived",
                                      pending_digest.size()));
        $display("Hashed %0d messages from %0d input words, checked %0d digest words,",
                 messages_sent, words_sent, digests_checked);
        $display("with sender-heavy, receiver-heavy and back-to-back pacing.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
